[rtl/gjd_pkg.sv]
// ----------------------------------------------------------------------------
// gjd_pkg: shared types and constants for the date / day number converter
// Beat structures, status codes, reciprocal constants for the fixed
// divisors and the small calendar tables.
// ----------------------------------------------------------------------------
package gjd_pkg;

  // request beat
  typedef struct packed {
    logic        func;
    logic [13:0] year_in;
    logic [3:0]  month_in;
    logic [4:0]  day_in;
    logic [22:0] jdn_in;
  } req_t;

  // result beat
  typedef struct packed {
    logic [22:0] jdn_out;
    logic [13:0] year_out;
    logic [3:0]  month_out;
    logic [4:0]  day_out;
    logic [2:0]  weekday_out;
    logic        leap_year;
    logic [1:0]  status;
  } rsp_t;

  // decoded date from the day number datapath
  typedef struct packed {
    logic [13:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic        leap;
  } date_t;

  // function codes
  localparam logic FUNC_TO_JDN  = 1'b0;
  localparam logic FUNC_TO_DATE = 1'b1;

  // status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_BAD_MONTH = 2'd1;
  localparam logic [1:0] ST_BAD_DAY   = 2'd2;
  localparam logic [1:0] ST_RANGE     = 2'd3;

  // accepted span: 0000-01-01 to 9999-12-31
  localparam logic [22:0] JDN_MIN  = 23'd1721060;
  localparam logic [22:0] JDN_MAX  = 23'd5373484;
  localparam logic [13:0] YEAR_MAX = 14'd9999;

  // conversion offsets
  localparam logic [23:0] JDN_OFFSET = 24'd32045;
  localparam logic [23:0] JDN_SHIFT  = 24'd32044;
  localparam logic [14:0] YEAR_BIAS  = 15'd4800;

  // ceiling reciprocals, exact over the operand ranges used here
  localparam logic [14:0] K_DIV100    = 15'd20972;     // shift 21
  localparam logic [24:0] K_DIV146097 = 25'd30103606;  // shift 42
  localparam logic [19:0] K_DIV1461   = 20'd734937;    // shift 30
  localparam logic [10:0] K_DIV153    = 11'd1714;      // shift 18
  localparam logic [23:0] K_DIV7      = 24'd9586981;   // shift 26

  // days in month 1..12, february without the leap day
  function automatic logic [4:0] month_len(input logic [3:0] month);
    logic [4:0] len;
    case (month)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                     len = 5'd30;
      4'd2:                                        len = 5'd28;
      default:                                     len = 5'd0;
    endcase
    return len;
  endfunction

  // days before march-based month m, (153 m + 2) / 5
  function automatic logic [8:0] month_start(input logic [3:0] m);
    logic [8:0] s;
    case (m)
      4'd0:    s = 9'd0;
      4'd1:    s = 9'd31;
      4'd2:    s = 9'd61;
      4'd3:    s = 9'd92;
      4'd4:    s = 9'd122;
      4'd5:    s = 9'd153;
      4'd6:    s = 9'd184;
      4'd7:    s = 9'd214;
      4'd8:    s = 9'd245;
      4'd9:    s = 9'd275;
      4'd10:   s = 9'd306;
      4'd11:   s = 9'd337;
      default: s = 9'd0;
    endcase
    return s;
  endfunction

endpackage

[rtl/gjd_rev.sv]
// ----------------------------------------------------------------------------
// gjd_rev: day number to date datapath
// Five register stages: 400-year cycle, 4-year cycle, month, then a short
// finishing step. The decoded date is formed combinationally from the stage 5 registers.
// ----------------------------------------------------------------------------
module gjd_rev (
  input  logic               clk,
  input  logic [22:0]        jdn,
  output gjd_pkg::date_t     date
);
  import gjd_pkg::*;

  // stage 1: shifted day number and 400-year quotient product
  logic [23:0] a0;
  logic [25:0] x0;
  logic [25:0] r1_x;
  logic [50:0] r1_p;

  assign a0 = {1'b0, jdn} + JDN_SHIFT;
  assign x0 = {a0, 2'b11};

  always_ff @(posedge clk) begin
    r1_x <= x0;
    r1_p <= {25'b0, x0} * {26'b0, K_DIV146097};
  end

  // stage 2: century count b and day within the century
  logic [7:0]  b1;
  logic [25:0] rem1;
  logic [7:0]  r2_b;
  logic [15:0] r2_c;

  assign b1   = r1_p[49:42];
  assign rem1 = r1_x - 26'({18'b0, b1} * 26'd146097);

  always_ff @(posedge clk) begin
    r2_b <= b1;
    r2_c <= rem1[17:2];
  end

  // stage 3: 4-year quotient product
  logic [17:0] x2;
  logic [7:0]  r3_b;
  logic [17:0] r3_x;
  logic [37:0] r3_p;

  assign x2 = {r2_c, 2'b11};

  always_ff @(posedge clk) begin
    r3_b <= r2_b;
    r3_x <= x2;
    r3_p <= {20'b0, x2} * {18'b0, K_DIV1461};
  end

  // stage 4: year within century and day within year
  logic [6:0]  d3;
  logic [17:0] rem3;
  logic [7:0]  r4_b;
  logic [6:0]  r4_d;
  logic [8:0]  r4_e;

  assign d3   = r3_p[36:30];
  assign rem3 = r3_x - 18'({11'b0, d3} * 18'd1461);

  always_ff @(posedge clk) begin
    r4_b <= r3_b;
    r4_d <= d3;
    r4_e <= rem3[10:2];
  end

  // stage 5: march-based month
  logic [10:0] t4;
  logic [21:0] pm4;
  logic [7:0]  r5_b;
  logic [6:0]  r5_d;
  logic [8:0]  r5_e;
  logic [3:0]  r5_m;

  assign t4  = 11'({2'b0, r4_e} * 11'd5) + 11'd2;
  assign pm4 = {11'b0, t4} * {11'b0, K_DIV153};

  always_ff @(posedge clk) begin
    r5_b <= r4_b;
    r5_d <= r4_d;
    r5_e <= r4_e;
    r5_m <= pm4[21:18];
  end

  // finish: calendar month, day, year and leap flag
  logic        m10;
  logic [6:0]  low;
  logic [8:0]  day9;
  logic [14:0] year15;
  logic        cent;
  logic [1:0]  cent_idx;

  assign m10      = (r5_m >= 4'd10);
  assign low      = r5_d + {6'b0, m10};
  assign day9     = 9'd1 + r5_e - month_start(r5_m);
  assign year15   = 15'({7'b0, r5_b} * 15'd100) + {8'b0, low} - YEAR_BIAS;
  assign cent     = (low == 7'd0) || (low == 7'd100);
  assign cent_idx = r5_b[1:0] + {1'b0, (low == 7'd100)};

  always_comb begin
    date.year  = year15[13:0];
    date.month = m10 ? r5_m - 4'd9 : r5_m + 4'd3;
    date.day   = day9[4:0];
    date.leap  = (year15[1:0] == 2'd0) && (!cent || (cent_idx == 2'd0));
  end

endmodule

[rtl/gregorian_julian_day_converter_top.sv]
// ----------------------------------------------------------------------------
// gregorian_julian_day_converter_top: Gregorian date / Julian day number
// Converts a date to its day number (func 0) or a day number to its date,
// weekday and leap flag (func 1), years 0 to 9999.
// ----------------------------------------------------------------------------
// A request beat is taken whenever start is high; busy is always low, so a
// new beat may enter every cycle. Each beat yields exactly one result beat,
// shown with done for one cycle once it has passed through the six register
// stages (five datapath stages with reciprocal multiplies for the constant
// divisors, then the output register); results leave in request order and
// must be taken when done is high.
module gregorian_julian_day_converter_top (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  gjd_pkg::req_t   req,
  output logic            busy,
  output logic            done,
  output gjd_pkg::rsp_t   rsp
);
  import gjd_pkg::*;

  typedef struct packed {
    logic        func;
    logic [1:0]  status;
    logic [22:0] jdn;
    logic [13:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic        leap;
  } info_t;

  logic       accept;
  logic [4:0] vld;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  // valid bits travel with the beats
  always_ff @(posedge clk) begin
    if (rst) begin
      vld  <= '0;
      done <= 1'b0;
    end else begin
      vld  <= {vld[3:0], accept};
      done <= vld[4];
    end
  end

  // stage 1: march-based year and month, divide-by-100 products
  logic        a0;
  logic [14:0] y0;
  logic [3:0]  m0;
  logic        s1_func;
  logic [13:0] s1_year;
  logic [3:0]  s1_month;
  logic [4:0]  s1_day;
  logic [22:0] s1_jdn;
  logic        s1_range_bad;
  logic [14:0] s1_y;
  logic [3:0]  s1_m;
  logic [29:0] s1_py;
  logic [28:0] s1_pyr;

  assign a0 = (req.month_in <= 4'd2);
  assign y0 = {1'b0, req.year_in} + YEAR_BIAS - {14'b0, a0};
  assign m0 = a0 ? req.month_in + 4'd9 : req.month_in - 4'd3;

  always_ff @(posedge clk) begin
    s1_func      <= req.func;
    s1_year      <= req.year_in;
    s1_month     <= req.month_in;
    s1_day       <= req.day_in;
    s1_jdn       <= req.jdn_in;
    s1_range_bad <= (req.jdn_in < JDN_MIN) || (req.jdn_in > JDN_MAX);
    s1_y         <= y0;
    s1_m         <= m0;
    s1_py        <= {15'b0, y0} * {15'b0, K_DIV100};
    s1_pyr       <= {15'b0, req.year_in} * {14'b0, K_DIV100};
  end

  // stage 2: leap flag, input checks, partial day number sums
  logic [7:0]  qy;
  logic [7:0]  qyr;
  logic        leap1;
  logic [4:0]  limit1;
  logic [1:0]  status1;
  logic [23:0] suma1;
  logic [23:0] sumb1;
  logic        s2_func;
  logic [1:0]  s2_status;
  logic [22:0] s2_jdn;
  logic [13:0] s2_year;
  logic [3:0]  s2_month;
  logic [4:0]  s2_day;
  logic        s2_leap;
  logic [23:0] s2_suma;
  logic [23:0] s2_sumb;

  assign qy     = s1_py[28:21];
  assign qyr    = s1_pyr[28:21];
  assign leap1  = (s1_year[1:0] == 2'd0) &&
                  ((s1_year != 14'({6'b0, qyr} * 14'd100)) || (qyr[1:0] == 2'd0));
  assign limit1 = month_len(s1_month) + {4'b0, ((s1_month == 4'd2) && leap1)};
  assign suma1  = 24'({9'b0, s1_y} * 24'd365) + {11'b0, s1_y[14:2]} + {19'b0, s1_day};
  assign sumb1  = {15'b0, month_start(s1_m)} + {18'b0, qy[7:2]} - {16'b0, qy};

  // status in check order: month, day, year; day number requests check range only
  always_comb begin
    if (s1_func == FUNC_TO_DATE) begin
      status1 = s1_range_bad ? ST_RANGE : ST_OK;
    end else if ((s1_month == 4'd0) || (s1_month > 4'd12)) begin
      status1 = ST_BAD_MONTH;
    end else if ((s1_day == 5'd0) || (s1_day > limit1)) begin
      status1 = ST_BAD_DAY;
    end else if (s1_year > YEAR_MAX) begin
      status1 = ST_RANGE;
    end else begin
      status1 = ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    s2_func   <= s1_func;
    s2_status <= status1;
    s2_jdn    <= s1_jdn;
    s2_year   <= s1_year;
    s2_month  <= s1_month;
    s2_day    <= s1_day;
    s2_leap   <= leap1;
    s2_suma   <= suma1;
    s2_sumb   <= sumb1;
  end

  // stage 3: final day number, either computed or the request's
  logic [23:0] jdn2;
  info_t       s3;

  assign jdn2 = s2_suma + s2_sumb - JDN_OFFSET;

  always_ff @(posedge clk) begin
    s3.func   <= s2_func;
    s3.status <= s2_status;
    s3.jdn    <= (s2_func == FUNC_TO_DATE) ? s2_jdn : jdn2[22:0];
    s3.year   <= s2_year;
    s3.month  <= s2_month;
    s3.day    <= s2_day;
    s3.leap   <= s2_leap;
  end

  // stage 4: divide-by-7 product
  info_t       s4;
  logic [46:0] s4_p7;

  always_ff @(posedge clk) begin
    s4    <= s3;
    s4_p7 <= {24'b0, s3.jdn} * {23'b0, K_DIV7};
  end

  // stage 5: weekday from the remainder
  logic [20:0] q7;
  info_t       s5;
  logic [2:0]  s5_wd;

  assign q7 = s4_p7[46:26];

  always_ff @(posedge clk) begin
    s5    <= s4;
    s5_wd <= s4.jdn[2:0] - 3'(q7[2:0] * 3'd7);
  end

  // day number to date, aligned with stage 5
  date_t rev_date;

  gjd_rev u_rev (
    .clk  (clk),
    .jdn  (req.jdn_in),
    .date (rev_date)
  );

  // output register: error beats carry only the status
  rsp_t rsp_next;

  always_comb begin
    rsp_next = '0;
    rsp_next.status = s5.status;
    if (s5.status == ST_OK) begin
      rsp_next.jdn_out     = s5.jdn;
      rsp_next.weekday_out = s5_wd;
      if (s5.func == FUNC_TO_DATE) begin
        rsp_next.year_out  = rev_date.year;
        rsp_next.month_out = rev_date.month;
        rsp_next.day_out   = rev_date.day;
        rsp_next.leap_year = rev_date.leap;
      end else begin
        rsp_next.year_out  = s5.year;
        rsp_next.month_out = s5.month;
        rsp_next.day_out   = s5.day;
        rsp_next.leap_year = s5.leap;
      end
    end
  end

  always_ff @(posedge clk) begin
    rsp <= rsp_next;
  end

endmodule
